/* design/cnlc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the card number Luhn classifier.
package cnlc_pkg;

  // Input and result field widths.
  localparam int CARD_W  = 63;
  localparam int BRAND_W = 2;
  localparam int COUNT_W = 5;
  localparam int SUM_W   = 8;

  // Decimal register: twenty BCD digits, scanned four digits at a time.
  localparam int DIGIT_W    = 4;
  localparam int BCD_DIGITS = 20;
  localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
  localparam int GROUP_DIGS = 4;
  localparam int GROUP_W    = GROUP_DIGS * DIGIT_W;

  // Binary to BCD conversion takes three bits of the card number a cycle.
  localparam int BITS_PER_STEP = 3;

  // Sequencer step counts.
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] CONV_STEPS = CNT_W'(CARD_W / BITS_PER_STEP);
  localparam logic [CNT_W-1:0] SCAN_STEPS = CNT_W'(BCD_DIGITS / GROUP_DIGS);

  // Brand codes.
  localparam logic [BRAND_W-1:0] BRAND_INVALID = 2'd0;
  localparam logic [BRAND_W-1:0] BRAND_PFX_3X  = 2'd1;
  localparam logic [BRAND_W-1:0] BRAND_PFX_4   = 2'd2;
  localparam logic [BRAND_W-1:0] BRAND_PFX_5X  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic convert;
    logic scan;
    logic finish;
  } cmd_t;

endpackage

/* design/card_number_luhn_classifier.sv */
`timescale 1ns / 1ps
// Top level of the card number Luhn classifier.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   card_number[62:0]
//   out      out_valid / out_ready brand[1:0], luhn_ok, digit_count[4:0], luhn_sum[7:0]
//
// One request at a time: binary to BCD conversion three bits a cycle, then a
// scan of four digits a cycle, then a decision step in the finish state.
// The result is registered when the finish state finds the result register
// free, and the controller then returns to idle to take a new request.
// The result register holds a finished result while the next request is
// worked on; a request finishes only once that register is free.
// Synchronous reset returns the controller to idle and empties the output.
module card_number_luhn_classifier
  import cnlc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CARD_W-1:0]  card_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BRAND_W-1:0] brand,
  output logic               luhn_ok,
  output logic [COUNT_W-1:0] digit_count,
  output logic [SUM_W-1:0]   luhn_sum
);

  cmd_t cmd;

  // Sequencer.
  cnlc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Arithmetic and result registers.
  cnlc_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .card_number (card_number),
    .brand       (brand),
    .luhn_ok     (luhn_ok),
    .digit_count (digit_count),
    .luhn_sum    (luhn_sum)
  );

endmodule

/* design/cnlc_dp.sv */
`timescale 1ns / 1ps
// Datapath: binary to BCD conversion, digit scan, Luhn sum and brand decision.
module cnlc_dp
  import cnlc_pkg::*;
(
  input  logic               clk,
  input  cmd_t               cmd,
  input  logic [CARD_W-1:0]  card_number,
  output logic [BRAND_W-1:0] brand,
  output logic               luhn_ok,
  output logic [COUNT_W-1:0] digit_count,
  output logic [SUM_W-1:0]   luhn_sum
);

  // One double-dabble step: adjust every digit, then shift one bit in.
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b,
                                             input logic bit_in);
    logic [BCD_W-1:0] a;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      a[i*DIGIT_W +: DIGIT_W] = (b[i*DIGIT_W +: DIGIT_W] >= 4'd5) ?
                                b[i*DIGIT_W +: DIGIT_W] + 4'd3 :
                                b[i*DIGIT_W +: DIGIT_W];
    end
    return {a[BCD_W-2:0], bit_in};
  endfunction

  // Luhn contribution of a digit in a doubled position.
  function automatic logic [DIGIT_W-1:0] luhn_dbl(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W:0] t;
    t = {d, 1'b0};
    if (t > 5'd9) begin
      t = t - 5'd9;
    end
    return t[DIGIT_W-1:0];
  endfunction

  // Remainder of a narrow sum by ten, by conditional subtraction.
  function automatic logic [DIGIT_W-1:0] mod10(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] r;
    r = v;
    if (r >= 8'd160) r = r - 8'd160;
    if (r >= 8'd80)  r = r - 8'd80;
    if (r >= 8'd40)  r = r - 8'd40;
    if (r >= 8'd20)  r = r - 8'd20;
    if (r >= 8'd10)  r = r - 8'd10;
    return r[DIGIT_W-1:0];
  endfunction

  logic [CARD_W-1:0]  bin;
  logic [BCD_W-1:0]   bcd;
  logic [COUNT_W-1:0] pos;
  logic [COUNT_W-1:0] count;
  logic [SUM_W-1:0]   sum;
  logic [DIGIT_W-1:0] hi;
  logic [DIGIT_W-1:0] lo;
  logic [DIGIT_W-1:0] prev;

  logic [BCD_W-1:0]   bcd_next;
  logic [DIGIT_W-1:0] d0, d1, d2, d3;
  logic [SUM_W-1:0]   grp_sum;
  logic               ok_next;
  logic [BRAND_W-1:0] brand_next;

  // Three conversion steps per cycle, most significant card bits first.
  always_comb begin
    bcd_next = dabble(bcd, bin[CARD_W-1]);
    bcd_next = dabble(bcd_next, bin[CARD_W-2]);
    bcd_next = dabble(bcd_next, bin[CARD_W-3]);
  end

  // Lowest remaining group of four digits and its Luhn contribution.
  assign d0 = bcd[0*DIGIT_W +: DIGIT_W];
  assign d1 = bcd[1*DIGIT_W +: DIGIT_W];
  assign d2 = bcd[2*DIGIT_W +: DIGIT_W];
  assign d3 = bcd[3*DIGIT_W +: DIGIT_W];
  assign grp_sum = {4'd0, d0} + {4'd0, luhn_dbl(d1)} + {4'd0, d2} +
                   {4'd0, luhn_dbl(d3)};

  // Final check and brand decision from the count and the leading two digits.
  always_comb begin
    ok_next    = (mod10(sum) == 4'd0);
    brand_next = BRAND_INVALID;
    if (ok_next) begin
      if (count == 5'd15 && hi == 4'd3 && (lo == 4'd4 || lo == 4'd7)) begin
        brand_next = BRAND_PFX_3X;
      end else if (count >= 5'd13 && count <= 5'd16 && hi == 4'd4) begin
        brand_next = BRAND_PFX_4;
      end else if (count == 5'd16 && hi == 4'd5 && lo >= 4'd1 && lo <= 4'd5) begin
        brand_next = BRAND_PFX_5X;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin   <= card_number;
      bcd   <= '0;
      pos   <= '0;
      count <= 5'd1;
      sum   <= '0;
      hi    <= '0;
      lo    <= '0;
      prev  <= '0;
    end else if (cmd.convert) begin
      bin <= {bin[CARD_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
      bcd <= bcd_next;
    end else if (cmd.scan) begin
      // The highest nonzero digit seen so far sets the count and the prefix.
      if (d3 != 4'd0) begin
        count <= pos + 5'd4;
        hi    <= d3;
        lo    <= d2;
      end else if (d2 != 4'd0) begin
        count <= pos + 5'd3;
        hi    <= d2;
        lo    <= d1;
      end else if (d1 != 4'd0) begin
        count <= pos + 5'd2;
        hi    <= d1;
        lo    <= d0;
      end else if (d0 != 4'd0) begin
        count <= pos + 5'd1;
        hi    <= d0;
        lo    <= prev;
      end
      sum  <= sum + grp_sum;
      prev <= d3;
      pos  <= pos + 5'd4;
      bcd  <= {{GROUP_W{1'b0}}, bcd[BCD_W-1:GROUP_W]};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      brand       <= brand_next;
      luhn_ok     <= ok_next;
      digit_count <= count;
      luhn_sum    <= sum;
    end
  end

endmodule

/* design/cnlc_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences conversion, digit scan and result hand-off.
module cnlc_ctrl
  import cnlc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    CONVERT,
    SCAN,
    FINISH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == IDLE);

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE:    cmd.load    = in_valid;
      CONVERT: cmd.convert = 1'b1;
      SCAN:    cmd.scan    = 1'b1;
      FINISH:  cmd.finish  = out_free;
      default: cmd = '0;
    endcase
  end

  // State, step counter and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= CONVERT;
            cnt   <= CONV_STEPS - 5'd1;
          end
        end
        CONVERT: begin
          if (cnt == '0) begin
            state <= SCAN;
            cnt   <= SCAN_STEPS - 5'd1;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        SCAN: begin
          if (cnt == '0) begin
            state <= FINISH;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the card number Luhn classifier.
module testbench;
  import cnlc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 2000;
  localparam int IDLE_PCT     = 22;

  // One classification result as the block reports it.
  typedef struct packed {
    logic [BRAND_W-1:0] brand;
    logic               ok;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
  } card_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CARD_W-1:0]  card_number = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [BRAND_W-1:0] brand;
  logic               luhn_ok;
  logic [COUNT_W-1:0] digit_count;
  logic [SUM_W-1:0]   luhn_sum;

  card_result_t pending_results[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           idle_on = 1'b1;

  card_number_luhn_classifier u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .card_number (card_number),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .brand       (brand),
    .luhn_ok     (luhn_ok),
    .digit_count (digit_count),
    .luhn_sum    (luhn_sum)
  );

  always #5 clk = ~clk;

  // Digit count, Luhn sum and brand of one card number.
  function automatic card_result_t classify_card(input logic [CARD_W-1:0] n);
    card_result_t     r;
    longint unsigned  rest;
    longint unsigned  lead;
    int unsigned      d;
    int unsigned      dbl;
    int unsigned      pos;
    int unsigned      total;
    int unsigned      hi;
    int unsigned      lo;
    rest  = {1'b0, n};
    lead  = {1'b0, n};
    pos   = 0;
    total = 0;
    // Zero still has one digit, so the loop body runs at least once.
    do begin
      d = 32'(rest % 10);
      if (pos % 2 == 1) begin
        dbl = d * 2;
        if (dbl > 9) dbl = dbl - 9;
        total += dbl;
      end else begin
        total += d;
      end
      rest = rest / 10;
      pos++;
    end while (rest != 0);
    r.count = COUNT_W'(pos);
    r.sum   = SUM_W'(total);
    r.ok    = (total % 10 == 0);
    r.brand = BRAND_INVALID;
    if (r.ok) begin
      // A leading value of exactly one hundred is kept and matches nothing.
      while (lead > 100) lead = lead / 10;
      hi = 32'(lead / 10);
      lo = 32'(lead % 10);
      if (pos == 15 && hi == 3 && (lo == 4 || lo == 7)) begin
        r.brand = BRAND_PFX_3X;
      end else if (pos >= 13 && pos <= 16 && hi == 4) begin
        r.brand = BRAND_PFX_4;
      end else if (pos == 16 && hi == 5 && lo >= 1 && lo <= 5) begin
        r.brand = BRAND_PFX_5X;
      end
    end
    return r;
  endfunction

  // Builds a number with the given leading digits and length and a valid check digit.
  function automatic logic [CARD_W-1:0] make_card(input int unsigned lead,
                                                  input int lead_digits,
                                                  input int total_digits);
    longint unsigned n;
    card_result_t    r;
    n = 64'(lead);
    for (int i = lead_digits; i < total_digits; i++) n = n * 10 + $urandom_range(9);
    n = n - n % 10;
    r = classify_card(CARD_W'(n));
    n = n + (10 - r.sum % 10) % 10;
    return CARD_W'(n);
  endfunction

  // Replaces the last digit so that the Luhn sum is no longer a multiple of ten.
  function automatic logic [CARD_W-1:0] break_luhn(input logic [CARD_W-1:0] n);
    longint unsigned v;
    longint unsigned d;
    v = {1'b0, n};
    d = v % 10;
    return CARD_W'(v - d + (d + 1 + $urandom_range(8)) % 10);
  endfunction

  // Random decimal number of the given length with a nonzero leading digit.
  function automatic logic [CARD_W-1:0] random_digits(input int len);
    longint unsigned n;
    // Nineteen-digit numbers start below 9 so they stay within 63 bits.
    n = (len == 19) ? 64'($urandom_range(8, 1)) : 64'($urandom_range(9, 1));
    for (int i = 1; i < len; i++) n = n * 10 + $urandom_range(9);
    return CARD_W'(n);
  endfunction

  // Sends one request and records the expected result once it is taken.
  task automatic send_card(input logic [CARD_W-1:0] n);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    card_number <= n;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(classify_card(n));
  endtask

  task automatic test_extremes();
    send_card('0);
    send_card({CARD_W{1'b1}});
    send_card(CARD_W'(9));
    send_card(CARD_W'(64'd1000000000000000000));
    send_card(random_digits(19));
  endtask

  task automatic test_brand_prefixes();
    send_card(make_card(34, 2, 15));
    send_card(make_card(37, 2, 15));
    send_card(make_card(4, 1, 13));
    send_card(make_card(4, 1, 16));
    send_card(make_card(51, 2, 16));
    send_card(make_card(55, 2, 16));
    // Near misses on length or leading digits.
    send_card(make_card(34, 2, 16));
    send_card(make_card(35, 2, 15));
    send_card(make_card(4, 1, 12));
    send_card(make_card(4, 1, 17));
    send_card(make_card(50, 2, 16));
    send_card(make_card(56, 2, 16));
  endtask

  task automatic test_prefix_reduction();
    send_card(make_card(100, 3, 16));
    send_card(make_card(100, 3, 4));
    send_card(CARD_W'(100));
  endtask

  task automatic test_luhn_failure();
    send_card(break_luhn(make_card(4, 1, 16)));
    send_card(break_luhn(make_card(37, 2, 15)));
    send_card(break_luhn(make_card(53, 2, 16)));
  endtask

  // Mostly well-formed card numbers, with random lengths and raw words mixed in.
  task automatic test_random_mix();
    logic [CARD_W-1:0] n;
    int                pick;
    int                len;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = !(i >= 300 && i < 600);
      pick = $urandom_range(99);
      if (pick < 55) begin
        case ($urandom_range(4))
          0: n = make_card($urandom_range(1) ? 34 : 37, 2, 15);
          1: n = make_card(4, 1, $urandom_range(16, 13));
          2: n = make_card($urandom_range(55, 51), 2, 16);
          3: n = make_card($urandom_range(99, 10), 2, $urandom_range(17, 12));
          default: n = make_card(100, 3, $urandom_range(19, 4));
        endcase
        if ($urandom_range(99) < 15) n = break_luhn(n);
      end else if (pick < 80) begin
        len = $urandom_range(19, 1);
        n = random_digits(len);
      end else begin
        n = CARD_W'({$urandom, $urandom});
      end
      send_card(n);
    end
    idle_on = 1'b1;
  endtask

  // Result side back-pressure.
  always @(negedge clk) begin
    out_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compares each taken result with the oldest expected one.
  always @(posedge clk) begin
    card_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Unexpected result: brand=%0d ok=%0d count=%0d sum=%0d",
                   brand, luhn_ok, digit_count, luhn_sum);
        end
      end else begin
        want = pending_results.pop_front();
        if (brand !== want.brand || luhn_ok !== want.ok ||
            digit_count !== want.count || luhn_sum !== want.sum) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $write("Mismatch: expected brand=%0d ok=%0d count=%0d sum=%0d, ",
                   want.brand, want.ok, want.count, want.sum);
            $display("got brand=%0d ok=%0d count=%0d sum=%0d",
                     brand, luhn_ok, digit_count, luhn_sum);
          end
        end
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_brand_prefixes();
    test_prefix_reduction();
    test_luhn_failure();
    test_random_mix();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/cnlc_pkg.sv
design/cnlc_dp.sv
design/cnlc_ctrl.sv
design/card_number_luhn_classifier.sv
tb/testbench.sv
